// ===== rtl/vfae_pkg.sv =====
// ----------------------------------------------------------------------------
// vfae_pkg: shared constants and types for the azimuth/elevation block
// Datapath widths, the CORDIC arctangent table and the cell control struct.
// ----------------------------------------------------------------------------
package vfae_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_STAGES        = 24;

   // CORDIC datapath width; covers the rotated vector plus CORDIC growth
   localparam int CW = 48;

   // 1/K in Q0.32
   localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
   // half turn of the 32 bit angle accumulator
   localparam logic [31:0] ANGLE_PI = 32'h8000_0000;
   localparam logic [31:0] ANGLE_HALF_LSB = 32'h0000_8000;

   localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic valid;
      logic zero;
   } cell_ctl_type;

endpackage

// ===== rtl/vfae_cell.sv =====
// ----------------------------------------------------------------------------
// vfae_cell: one CORDIC vectoring iteration
// Rotates toward the x axis by a fixed arctangent and hands off to the next cell.
// ----------------------------------------------------------------------------
module vfae_cell
   import vfae_pkg::*;
#(
   parameter int          SHIFT = 0,
   parameter logic [31:0] ATAN  = 32'd0,
   parameter int          SW    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  cell_ctl_type         ctl_i,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic [31:0]          z_i,
   input  logic [SW-1:0]        side_i,
   output cell_ctl_type         ctl_o,
   output logic signed [CW-1:0] x_o,
   output logic signed [CW-1:0] y_o,
   output logic [31:0]          z_o,
   output logic [SW-1:0]        side_o
);

   cell_ctl_type         ctl_ff;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic [31:0]          z_ff, z_in;
   logic [SW-1:0]        side_ff;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      xs = x_i >>> SHIFT;
      ys = y_i >>> SHIFT;
      if (!y_i[CW-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign side_o = side_ff;

endmodule

// ===== rtl/vfae_cordic.sv =====
// ----------------------------------------------------------------------------
// vfae_cordic: CORDIC vectoring chain
// Quadrant fold and zero check, then one cell per iteration.
// ----------------------------------------------------------------------------
module vfae_cordic
   import vfae_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int SW     = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_i,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic [SW-1:0]        side_i,
   output cell_ctl_type         ctl_o,
   output logic signed [CW-1:0] mag_o,
   output logic [31:0]          angle_o,
   output logic [SW-1:0]        side_o
);

   cell_ctl_type         ctl_c  [STAGES+1];
   logic signed [CW-1:0] x_c    [STAGES+1];
   logic signed [CW-1:0] y_c    [STAGES+1];
   logic [31:0]          z_c    [STAGES+1];
   logic [SW-1:0]        side_c [STAGES+1];

   cell_ctl_type         ctl_ff, ctl_in;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic [31:0]          z_ff, z_in;
   logic [SW-1:0]        side_ff;

   // fold the left half plane by turning pi
   always_comb begin
      ctl_in.valid = valid_i;
      ctl_in.zero  = (x_i == '0) && (y_i == '0);
      if (x_i[CW-1]) begin
         x_in = -x_i;
         y_in = -y_i;
         z_in = ANGLE_PI;
      end else begin
         x_in = x_i;
         y_in = y_i;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign ctl_c[0]  = ctl_ff;
   assign x_c[0]    = x_ff;
   assign y_c[0]    = y_ff;
   assign z_c[0]    = z_ff;
   assign side_c[0] = side_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      vfae_cell #(
         .SHIFT (i),
         .ATAN  (ATAN_TAB[i]),
         .SW    (SW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctl_i  (ctl_c[i]),
         .x_i    (x_c[i]),
         .y_i    (y_c[i]),
         .z_i    (z_c[i]),
         .side_i (side_c[i]),
         .ctl_o  (ctl_c[i+1]),
         .x_o    (x_c[i+1]),
         .y_o    (y_c[i+1]),
         .z_o    (z_c[i+1]),
         .side_o (side_c[i+1])
      );
   end

   assign ctl_o   = ctl_c[STAGES];
   assign mag_o   = x_c[STAGES];
   assign angle_o = z_c[STAGES];
   assign side_o  = side_c[STAGES];

endmodule

// ===== rtl/view_frame_azimuth_elevation.sv =====
// ----------------------------------------------------------------------------
// view_frame_azimuth_elevation: yaw and pitch turn angles to a target
// Yaw rotation, CORDIC vectoring for azimuth and length, gain correction,
// pitch rotation and a second CORDIC vectoring pass for elevation.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; each CORDIC iteration is its own cell.
// The whole pipeline holds while a finished result waits on rsp_ready.
// Reset clears all valid flags; payload registers are not reset.
module view_frame_azimuth_elevation
   import vfae_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_cos_yaw,
   input  logic signed [15:0] req_sin_yaw,
   input  logic signed [15:0] req_pitch_cos,
   input  logic signed [15:0] req_pitch_sin,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic signed [23:0] req_target_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_yaw_turn,
   output logic signed [15:0] rsp_pitch_turn
);

   localparam int SW1 = 16 + 16 + 24;
   localparam int SW2 = 16;

   logic en;

   // stage 1: yaw products
   logic               v1_ff;
   logic signed [39:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [15:0] cp1_ff, sp1_ff;
   logic signed [23:0] tz1_ff;

   // first CORDIC
   logic signed [CW-1:0] hx, hy;
   cell_ctl_type         c1_ctl;
   logic signed [CW-1:0] c1_mag;
   logic [31:0]          c1_ang;
   logic [SW1-1:0]       c1_side;

   // gain correction
   logic               g1_v_ff, g2_v_ff;
   logic [63:0]        mlo_ff;
   logic [CW-1:0]      mhi_ff;
   logic [31:0]        yaw_rnd;
   logic [15:0]        yaw_in, yaw1_ff, yaw2_ff, yaw3_ff;
   logic signed [15:0] cp_g1_ff, sp_g1_ff, cp_g2_ff, sp_g2_ff;
   logic signed [23:0] tz_g1_ff, tz_g2_ff;
   logic signed [CW-1:0] len_ff;

   // pitch products
   logic               p1_v_ff;
   logic signed [63:0] qa_ff, qc_ff;
   logic signed [39:0] qb_ff, qd_ff;
   logic signed [63:0] dx, dy;
   logic signed [CW-1:0] px, py;

   // second CORDIC
   cell_ctl_type         c2_ctl;
   logic signed [CW-1:0] c2_mag;
   logic [31:0]          c2_ang;
   logic [SW2-1:0]       c2_side;
   logic [31:0]          pitch_rnd;

   logic        rsp_valid_ff;
   logic [15:0] yaw_out_ff, pitch_out_ff;

   // the magnitude of the pitch pass is not needed
   logic unused_mag;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         g1_v_ff <= 1'b0;
         g2_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= req_valid;
         g1_v_ff <= c1_ctl.valid;
         g2_v_ff <= g1_v_ff;
         p1_v_ff <= g2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= 40'(req_cos_yaw) * 40'(req_target_x);
         pb_ff  <= 40'(req_sin_yaw) * 40'(req_target_y);
         pc_ff  <= 40'(req_sin_yaw) * 40'(req_target_x);
         pd_ff  <= 40'(req_cos_yaw) * 40'(req_target_y);
         cp1_ff <= req_pitch_cos;
         sp1_ff <= req_pitch_sin;
         tz1_ff <= req_target_z;
      end
   end

   assign hx = CW'(pa_ff) - CW'(pb_ff);
   assign hy = CW'(pc_ff) + CW'(pd_ff);

   vfae_cordic #(
      .STAGES (CORDIC_STAGES),
      .SW     (SW1)
   ) u_cordic_yaw (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (v1_ff),
      .x_i     (hx),
      .y_i     (hy),
      .side_i  ({cp1_ff, sp1_ff, tz1_ff}),
      .ctl_o   (c1_ctl),
      .mag_o   (c1_mag),
      .angle_o (c1_ang),
      .side_o  (c1_side)
   );

   // round half up at bit 16; zero vector gives zero
   assign yaw_rnd = c1_ang + ANGLE_HALF_LSB;
   assign yaw_in  = c1_ctl.zero ? 16'd0 : yaw_rnd[31:16];

   always_ff @(posedge clock) begin
      if (en) begin
         mlo_ff   <= 64'(c1_mag[31:0]) * 64'(INV_GAIN);
         mhi_ff   <= CW'(c1_mag[CW-1:32]) * CW'(INV_GAIN);
         yaw1_ff  <= yaw_in;
         cp_g1_ff <= c1_side[SW1-1 -: 16];
         sp_g1_ff <= c1_side[SW1-17 -: 16];
         tz_g1_ff <= c1_side[23:0];
         len_ff   <= mhi_ff + CW'(mlo_ff[63:32]);
         yaw2_ff  <= yaw1_ff;
         cp_g2_ff <= cp_g1_ff;
         sp_g2_ff <= sp_g1_ff;
         tz_g2_ff <= tz_g1_ff;
         qa_ff    <= 64'(cp_g2_ff) * 64'(len_ff);
         qc_ff    <= 64'(sp_g2_ff) * 64'(len_ff);
         qb_ff    <= 40'(sp_g2_ff) * 40'(tz_g2_ff);
         qd_ff    <= 40'(cp_g2_ff) * 40'(tz_g2_ff);
         yaw3_ff  <= yaw2_ff;
      end
   end

   // height sits 15 bits up in length units; floor shift back by 15
   assign dx = qa_ff - (64'(qb_ff) <<< 15);
   assign dy = qc_ff + (64'(qd_ff) <<< 15);
   assign px = CW'(dx >>> 15);
   assign py = CW'(dy >>> 15);

   vfae_cordic #(
      .STAGES (CORDIC_STAGES),
      .SW     (SW2)
   ) u_cordic_pitch (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (p1_v_ff),
      .x_i     (px),
      .y_i     (py),
      .side_i  (yaw3_ff),
      .ctl_o   (c2_ctl),
      .mag_o   (c2_mag),
      .angle_o (c2_ang),
      .side_o  (c2_side)
   );

   assign pitch_rnd = c2_ang + ANGLE_HALF_LSB;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= c2_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_out_ff   <= c2_side;
         pitch_out_ff <= c2_ctl.zero ? 16'd0 : pitch_rnd[31:16];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_yaw_turn   = $signed(yaw_out_ff);
   assign rsp_pitch_turn = $signed(pitch_out_ff);

   assign unused_mag = ^c2_mag;

   a_stall_only_on_backpressure : assert property (
      @(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready)
   ) else $error("input stalled without output backpressure");

   a_empty_after_reset : assert property (
      @(posedge clock) reset |=> !rsp_valid
   ) else $error("result valid right after reset");

   a_hold_first_stage : assert property (
      @(posedge clock) disable iff (reset)
      !en |=> $stable(v1_ff) && $stable(g1_v_ff) && $stable(p1_v_ff)
   ) else $error("pipeline moved during a stall");

endmodule

// ===== tb/view_frame_azimuth_elevation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_frame_azimuth_elevation_tb: self-checking bench for the turn angle block
// Feeds directed and random viewer/target beats with random gaps on both
// channels, predicts yaw and pitch turn angles with a bit-exact CORDIC model
// and compares every response beat in order.
// ----------------------------------------------------------------------------
module view_frame_azimuth_elevation_tb;
   import vfae_pkg::*;

   localparam int STAGES      = (CORDIC_STAGES_DEF > MAX_STAGES) ? MAX_STAGES
                                                                 : CORDIC_STAGES_DEF;
   localparam int LATENCY     = 2 * CORDIC_STAGES_DEF + 7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int NUM_RANDOM  = 1900;

   typedef struct packed {
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
      logic signed [15:0] pitch_cos;
      logic signed [15:0] pitch_sin;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [23:0] target_z;
   } view_beat_type;

   typedef struct packed {
      logic signed [15:0] yaw_turn;
      logic signed [15:0] pitch_turn;
   } turn_beat_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_cos_yaw;
   logic signed [15:0] req_sin_yaw;
   logic signed [15:0] req_pitch_cos;
   logic signed [15:0] req_pitch_sin;
   logic signed [23:0] req_target_x;
   logic signed [23:0] req_target_y;
   logic signed [23:0] req_target_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_yaw_turn;
   logic signed [15:0] rsp_pitch_turn;

   view_beat_type view_queue[$];
   turn_beat_type turn_expected[$];
   int            mismatch_count;
   int            cycle_count;
   int            req_gap;
   int            rsp_gap;

   view_frame_azimuth_elevation uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cos_yaw    (req_cos_yaw),
      .req_sin_yaw    (req_sin_yaw),
      .req_pitch_cos  (req_pitch_cos),
      .req_pitch_sin  (req_pitch_sin),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .req_target_z   (req_target_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_yaw_turn   (rsp_yaw_turn),
      .rsp_pitch_turn (rsp_pitch_turn)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // CORDIC vectoring: 32 bit angle, magnitude still scaled by the gain
   function automatic logic [31:0] vector_angle(input longint x_in, input longint y_in,
                                                output longint mag);
      longint      x;
      longint      y;
      longint      xs;
      longint      ys;
      logic [31:0] acc;
      x   = x_in;
      y   = y_in;
      acc = '0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return '0;
      end
      if (x < 0) begin
         x   = -x;
         y   = -y;
         acc = ANGLE_PI;
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x   = x + ys;
            y   = y - xs;
            acc = acc + ATAN_TAB[i];
         end else begin
            x   = x - ys;
            y   = y + xs;
            acc = acc - ATAN_TAB[i];
         end
      end
      mag = x;
      return acc;
   endfunction

   function automatic logic [15:0] round_angle(input logic [31:0] acc);
      logic [31:0] sum;
      sum = acc + ANGLE_HALF_LSB;
      return sum[31:16];
   endfunction

   function automatic turn_beat_type predict_turns(input view_beat_type b);
      longint        hx;
      longint        hy;
      longint        mag;
      longint        len;
      longint        zh;
      longint        px;
      longint        py;
      logic [63:0]   u;
      logic [63:0]   inv;
      logic [31:0]   yaw_acc;
      logic [31:0]   pitch_acc;
      turn_beat_type r;
      hx      = longint'(b.cos_yaw) * longint'(b.target_x)
              - longint'(b.sin_yaw) * longint'(b.target_y);
      hy      = longint'(b.sin_yaw) * longint'(b.target_x)
              + longint'(b.cos_yaw) * longint'(b.target_y);
      yaw_acc = vector_angle(hx, hy, mag);
      // remove the CORDIC gain, truncated
      u       = mag;
      inv     = {32'd0, INV_GAIN};
      len     = longint'((u >> 32) * inv + (((u & 64'hFFFF_FFFF) * inv) >> 32));
      zh      = longint'(b.target_z) * 32768;
      px      = (longint'(b.pitch_cos) * len - longint'(b.pitch_sin) * zh) >>> 15;
      py      = (longint'(b.pitch_sin) * len + longint'(b.pitch_cos) * zh) >>> 15;
      pitch_acc    = vector_angle(px, py, mag);
      r.yaw_turn   = round_angle(yaw_acc);
      r.pitch_turn = round_angle(pitch_acc);
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic add_view(input int cy, input int sy, input int cp, input int sp,
                           input int tx, input int ty, input int tz);
      view_beat_type b;
      b.cos_yaw   = 16'(cy);
      b.sin_yaw   = 16'(sy);
      b.pitch_cos = 16'(cp);
      b.pitch_sin = 16'(sp);
      b.target_x  = 24'(tx);
      b.target_y  = 24'(ty);
      b.target_z  = 24'(tz);
      view_queue.push_back(b);
   endtask

   function automatic int unit_trig(input real a, input bit use_sin);
      real v;
      v = use_sin ? $sin(a) : $cos(a);
      return int'(v * 32767.0);
   endfunction

   // random target: full range or scaled down so small offsets show up too
   function automatic int rand_target();
      int v;
      v = $urandom;
      v = (v <<< 8) >>> 8;
      if ($urandom_range(2) != 0) v = v >>> $urandom_range(22);
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) turn_expected.push_back(predict_turns(
            {req_cos_yaw, req_sin_yaw, req_pitch_cos, req_pitch_sin,
             req_target_x, req_target_y, req_target_z}));
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (view_queue.size() > 0) begin
               view_beat_type b;
               b = view_queue.pop_front();
               req_valid     <= 1'b1;
               req_cos_yaw   <= b.cos_yaw;
               req_sin_yaw   <= b.sin_yaw;
               req_pitch_cos <= b.pitch_cos;
               req_pitch_sin <= b.pitch_sin;
               req_target_x  <= b.target_x;
               req_target_y  <= b.target_y;
               req_target_z  <= b.target_z;
               req_gap       <= (cycle_count % 3000 < 600) ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (turn_expected.size() == 0) begin
               report_mismatch("unexpected beat", rsp_yaw_turn, 0);
            end else begin
               turn_beat_type e;
               e = turn_expected.pop_front();
               if (rsp_yaw_turn !== e.yaw_turn)
                  report_mismatch("yaw_turn", rsp_yaw_turn, e.yaw_turn);
               if (rsp_pitch_turn !== e.pitch_turn)
                  report_mismatch("pitch_turn", rsp_pitch_turn, e.pitch_turn);
            end
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap   <= rsp_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap   <= (cycle_count % 3000 >= 1500 && cycle_count % 3000 < 2100)
                         ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      real ay;
      real ap;
      reset = 1'b1;

      // directed: zero vectors, axis directions, negative x, field extremes
      add_view(32767, 0, 32767, 0, 0, 0, 0);
      add_view(32767, 0, 32767, 0, 256, 0, 0);
      add_view(32767, 0, 32767, 0, 0, 256, 0);
      add_view(32767, 0, 32767, 0, -256, 0, 0);
      add_view(32767, 0, 32767, 0, 0, -256, 0);
      add_view(32767, 0, 32767, 0, 0, 0, 256);
      add_view(32767, 0, 32767, 0, 0, 0, -256);
      add_view(32767, 0, 32767, 0, -256, -1, 0);
      add_view(32767, 0, 32767, 0, -256, 1, 5);
      add_view(0, 0, 0, 0, 1000, 2000, 3000);
      add_view(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
      add_view(-32768, -32768, -32768, -32768, -8388608, -8388608, -8388608);
      add_view(32767, 32767, 32767, 32767, -8388608, 8388607, -8388608);
      add_view(-32768, 32767, 32767, -32768, 8388607, -8388608, 8388607);
      add_view(32767, -32768, -32768, 32767, -8388608, -8388608, 8388607);
      add_view(0, 32767, 0, -32768, 1, -1, 1);
      add_view(23170, 23170, 23170, -23170, 12345, -6789, 4321);
      add_view(32767, 0, 32767, 0, 8388607, 0, 0);
      add_view(-32768, 0, 32767, 0, 8388607, 0, 0);
      add_view(12000, -31000, -5000, 9000, 1, 1, -1);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if ($urandom_range(99) < 75) begin
            ay = $urandom_range(65535) * 6.283185307 / 65536.0;
            ap = $urandom_range(65535) * 6.283185307 / 65536.0;
            add_view(unit_trig(ay, 0), unit_trig(ay, 1), unit_trig(ap, 0),
                     unit_trig(ap, 1), rand_target(), rand_target(), rand_target());
         end else begin
            add_view($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                     $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                     rand_target(), rand_target(), rand_target());
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (view_queue.size() > 0 || req_valid) @(posedge clock);
      while (turn_expected.size() > 0) @(posedge clock);
      repeat (LATENCY + 50) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
